// ===== hw/rtl/loss_list_range_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Loss-list range decoder assertion macros
// Shared concurrent assertion helpers, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef LOSS_LIST_RANGE_DECODER_DEFINES_SVH
`define LOSS_LIST_RANGE_DECODER_DEFINES_SVH

// same-cycle implication
`define LLRD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LLRD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/llrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Loss-list range decoder package
// Field widths, flag positions and the structs passed between stages.
// ----------------------------------------------------------------------------
package llrd_pkg;

   localparam int WordWidth = 32;
   localparam int SeqWidth  = 31;
   localparam int StartBit  = 31;   // range start flag in a payload word
   localparam int HalfBit   = 30;   // set in the distance when end is before start

   localparam logic StatusOk  = 1'b0;
   localparam logic StatusBad = 1'b1;

   typedef logic [SeqWidth-1:0] seq_type;

   // one registered input item
   typedef struct packed {
      logic [WordWidth-1:0] payload_word;
      logic                 end_of_payload;
   } word_type;

   // one result item
   typedef struct packed {
      seq_type range_first;
      seq_type range_last;
      logic    status;
      logic    payload_done;
   } result_type;

   // handshake status from the decoder
   typedef struct packed {
      logic consume;   // registered input item retires this cycle
      logic res_vld;   // that item gives a result
   } ctl_type;

endpackage

// ===== hw/rtl/llrd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Loss-list range decoder input stage
// Registers one payload word and its last-word flag; refills in the cycle
// the held item retires.
// ----------------------------------------------------------------------------
module llrd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  llrd_pkg::word_type   req_item,
   input  logic                 consume,
   output logic                 in_vld,
   output llrd_pkg::word_type   in_item
);

   logic               vld_ff;
   logic               vld_in;
   llrd_pkg::word_type item_ff;
   logic               take;

   // free when empty or the held item leaves now
   assign req_ready = !vld_ff || consume;
   assign take      = req_valid && req_ready;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (consume) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign in_vld  = vld_ff;
   assign in_item = item_ff;

endmodule

// ===== hw/rtl/llrd_decode.sv =====
// ----------------------------------------------------------------------------
// Loss-list range decoder core
// Phase machine and held range start; classifies each word into a single
// loss, a range, an error or nothing.
// ----------------------------------------------------------------------------
module llrd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  llrd_pkg::word_type   in_item,
   input  logic                 out_free,
   output llrd_pkg::ctl_type    ctl,
   output llrd_pkg::result_type result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HELD,
      PH_DROP
   } phase_type;

   phase_type         phase_ff;
   phase_type         phase_in;
   llrd_pkg::seq_type held_ff;
   llrd_pkg::seq_type held_in;
   llrd_pkg::seq_type seq;
   llrd_pkg::seq_type fwd_dist;
   logic              is_start;
   logic              eop;
   logic              res_vld;
   logic              consume;

   assign seq      = in_item.payload_word[llrd_pkg::SeqWidth-1:0];
   assign is_start = in_item.payload_word[llrd_pkg::StartBit];
   assign eop      = in_item.end_of_payload;
   // circular distance from held start to this end
   assign fwd_dist = seq - held_ff;

   // per-word decision
   always_comb begin
      phase_in            = phase_ff;
      held_in             = held_ff;
      res_vld             = 1'b0;
      result.range_first  = '0;
      result.range_last   = '0;
      result.status       = llrd_pkg::StatusOk;
      result.payload_done = eop;
      case (phase_ff)
         PH_DROP: begin
            if (eop) begin
               phase_in = PH_IDLE;
            end
         end
         PH_HELD: begin
            res_vld = 1'b1;
            held_in = '0;
            if (is_start || fwd_dist[llrd_pkg::HalfBit]) begin
               result.status = llrd_pkg::StatusBad;
               phase_in      = eop ? PH_IDLE : PH_DROP;
            end else begin
               result.range_first = held_ff;
               result.range_last  = seq;
               phase_in           = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (!is_start) begin
               res_vld            = 1'b1;
               result.range_first = seq;
               result.range_last  = seq;
            end else if (eop) begin
               // start word closing the payload
               res_vld       = 1'b1;
               result.status = llrd_pkg::StatusBad;
               held_in       = '0;
            end else begin
               held_in  = seq;
               phase_in = PH_HELD;
            end
         end
      endcase
   end

   // retire when the result, if any, has room
   assign consume     = in_vld && (!res_vld || out_free);
   assign ctl.consume = consume;
   assign ctl.res_vld = res_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
      end else if (consume) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== hw/rtl/llrd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Loss-list range decoder output stage
// Result register; reloads in the cycle its item is taken.
// ----------------------------------------------------------------------------
module llrd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  llrd_pkg::result_type load_item,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output llrd_pkg::result_type rsp_item
);

   logic                 vld_ff;
   logic                 vld_in;
   llrd_pkg::result_type item_ff;

   assign out_free = !vld_ff || rsp_ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_item  = item_ff;

endmodule

// ===== hw/rtl/loss_list_range_decoder.sv =====
// ----------------------------------------------------------------------------
// Loss-list range decoder
// Turns a loss-report payload, one word per item, into lost-sequence ranges.
//
//   channel  direction  fields
//   req_     in         payload_word[31:0], end_of_payload
//   rsp_     out        range_first[30:0], range_last[30:0], status,
//                       payload_done
//
// One item per cycle sustained while results are not stalled; a word waits in the input
// register and its result in the result register until rsp_ready takes it.
// Range starts that do not close the payload and words dropped after an error give no result item.
// Reset clears the phase machine and both valid flags.
// A stalled result register holds only words that would give a result;
// silent words still retire behind it.
// ----------------------------------------------------------------------------
module loss_list_range_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_payload_word,
   input  logic        req_end_of_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_range_first,
   output logic [30:0] rsp_range_last,
   output logic        rsp_status,
   output logic        rsp_payload_done
);

`include "loss_list_range_decoder_defines.svh"

   llrd_pkg::word_type   req_item;
   llrd_pkg::word_type   in_item;
   logic                 in_vld;
   llrd_pkg::ctl_type    ctl;
   llrd_pkg::result_type dec_result;
   llrd_pkg::result_type rsp_item;
   logic                 out_free;
   llrd_pkg::seq_type    chk_dist;

   assign req_item.payload_word   = req_payload_word;
   assign req_item.end_of_payload = req_end_of_payload;

   llrd_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .consume   (ctl.consume),
      .in_vld    (in_vld),
      .in_item   (in_item)
   );

   llrd_decode u_dec (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld),
      .in_item  (in_item),
      .out_free (out_free),
      .ctl      (ctl),
      .result   (dec_result)
   );

   llrd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (ctl.consume && ctl.res_vld),
      .load_item (dec_result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_range_first  = rsp_item.range_first;
   assign rsp_range_last   = rsp_item.range_last;
   assign rsp_status       = rsp_item.status;
   assign rsp_payload_done = rsp_item.payload_done;

   // distance of a delivered range, for checking
   assign chk_dist = rsp_range_last - rsp_range_first;

   `LLRD_ASSERT_IMP(a_err_zero, rsp_valid && rsp_status == llrd_pkg::StatusBad, rsp_range_first == '0 && rsp_range_last == '0, "error item with nonzero range")
   `LLRD_ASSERT_IMP(a_range_order, rsp_valid && rsp_status == llrd_pkg::StatusOk, !chk_dist[llrd_pkg::HalfBit], "range end before start")
   `LLRD_ASSERT_IMP(a_no_overwrite, rsp_valid && !rsp_ready && ctl.res_vld, !ctl.consume, "result overwritten while stalled")
   `LLRD_ASSERT_NXT(a_result_lands, ctl.consume && ctl.res_vld, rsp_valid, "retired result not presented")

endmodule
